@@ src/wlb_pkg.sv @@
// ----------------------------------------------------------------------------
// wlb_pkg
// Shared types, constants and codes for the worker load balancer.
// ----------------------------------------------------------------------------
package wlb_pkg;

  localparam int NUM_WORKERS = 16;
  localparam int IDX_W       = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int CNT_W       = $clog2(NUM_WORKERS + 1);

  localparam int KIND_W   = 2;
  localparam int WORKER_W = 4;
  localparam int STATUS_W = 2;
  localparam int LOAD_W   = 16;
  localparam int POOL_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [WORKER_W-1:0] worker_t;
  typedef logic [LOAD_W-1:0]   load_t;
  typedef logic [POOL_W-1:0]   pool_t;

  localparam load_t MAX_LOAD      = 16'hFFFF;
  localparam load_t DEFAULT_LIMIT = 16'd1000;
  localparam pool_t DEFAULT_POOL  = 5'd10;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACQUIRE = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_UNKNOWN = 2'd3
  } wlb_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2,
    ST_RSVD    = 2'd3
  } wlb_status_e;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic rd_en;
    idx_t scan_idx;
    logic commit;
  } wlb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_scan;
    idx_t scan_last;
    logic out_busy;
  } wlb_sts_t;

endpackage

@@ src/wlb_channels.sv @@
// ----------------------------------------------------------------------------
// wlb channels
// Valid/ready channel interfaces for requests, results and register writes.
// ----------------------------------------------------------------------------
interface wlb_req_if;
  logic                          valid;
  logic                          ready;
  logic [wlb_pkg::KIND_W-1:0]    kind;
  logic [wlb_pkg::WORKER_W-1:0]  worker;
  modport source (output valid, kind, worker, input ready);
  modport sink   (input valid, kind, worker, output ready);
endinterface

interface wlb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [wlb_pkg::WORKER_W-1:0]  assigned;
  logic [wlb_pkg::STATUS_W-1:0]  status;
  logic                          retired;
  logic [wlb_pkg::LOAD_W-1:0]    load;
  modport source (output valid, assigned, status, retired, load, input ready);
  modport sink   (input valid, assigned, status, retired, load, output ready);
endinterface

interface wlb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wlb_pkg::CFG_IDX_W-1:0]   index;
  logic [wlb_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/wlb_ctrl.sv @@
// ----------------------------------------------------------------------------
// wlb_ctrl
// Sequencer: accepts a request, walks the slot scan if needed, then commits.
// ----------------------------------------------------------------------------
module wlb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  wlb_pkg::wlb_sts_t sts_i,
  output wlb_pkg::wlb_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0]    state_q, state_d;
  wlb_pkg::idx_t scan_q, scan_d;

  always_comb begin
    state_d        = state_q;
    scan_d         = scan_q;
    req_ready_o    = 1'b0;
    cmd_o.load_req = 1'b0;
    cmd_o.rd_en    = 1'b0;
    cmd_o.scan_idx = scan_q;
    cmd_o.commit   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          scan_d         = '0;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts_i.needs_scan) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.rd_en = 1'b1;
          if (scan_q == sts_i.scan_last) begin
            state_d = S_DRAIN;
          end else begin
            scan_d = scan_q + wlb_pkg::idx_t'(1);
          end
        end
      end
      S_DRAIN: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the output register can take the result
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
    end
  end

endmodule

@@ src/wlb_datapath.sv @@
// ----------------------------------------------------------------------------
// wlb_datapath
// Count memory, live set, config registers, scan evaluation and result register.
// ----------------------------------------------------------------------------
module wlb_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [wlb_pkg::KIND_W-1:0]           req_kind_i,
  input  logic [wlb_pkg::WORKER_W-1:0]         req_worker_i,
  input  logic                                 cfg_valid_i,
  input  logic [wlb_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [wlb_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 rsp_ready_i,
  output logic                                 rsp_valid_o,
  output logic [wlb_pkg::WORKER_W-1:0]         rsp_assigned_o,
  output logic [wlb_pkg::STATUS_W-1:0]         rsp_status_o,
  output logic                                 rsp_retired_o,
  output logic [wlb_pkg::LOAD_W-1:0]           rsp_load_o,
  input  wlb_pkg::wlb_cmd_t                    cmd_i,
  output wlb_pkg::wlb_sts_t                    sts_o
);

  // configuration
  logic                 mode_q;
  wlb_pkg::pool_t       pool_q;
  wlb_pkg::load_t       limit_q;

  // request
  wlb_pkg::wlb_kind_e   kind_q;
  wlb_pkg::worker_t     worker_q;

  // count store with per-entry valid bits, live set
  wlb_pkg::load_t                     mem_q [wlb_pkg::NUM_WORKERS];
  logic [wlb_pkg::NUM_WORKERS-1:0]    cnt_vld_q;
  logic [wlb_pkg::NUM_WORKERS-1:0]    live_q;
  wlb_pkg::cnt_t                      live_total_q;

  // read pipe
  wlb_pkg::idx_t        rd_addr;
  wlb_pkg::load_t       rd_data_q;
  logic                 rd_cvld_q;
  logic                 rd_pend_q;
  logic                 rd_first_q;
  wlb_pkg::idx_t        rd_idx_q;

  // scan results
  wlb_pkg::idx_t        best_idx_q;
  wlb_pkg::load_t       best_val_q;
  logic                 hit_q;
  wlb_pkg::idx_t        hit_idx_q;
  wlb_pkg::load_t       hit_val_q;
  logic                 idle_fnd_q;
  wlb_pkg::idx_t        idle_idx_q;

  // result register
  logic                 out_vld_q;
  wlb_pkg::worker_t     out_assigned_q;
  wlb_pkg::wlb_status_e out_status_q;
  logic                 out_retired_q;
  wlb_pkg::load_t       out_load_q;

  wlb_pkg::idx_t        pool_last;
  wlb_pkg::idx_t        worker_idx;
  logic                 worker_in_range;
  logic                 rel_ok;
  wlb_pkg::load_t       lim_eff;
  wlb_pkg::load_t       cur_val;
  logic                 cur_live;

  wlb_pkg::worker_t     res_assigned;
  wlb_pkg::wlb_status_e res_status;
  logic                 res_retired;
  wlb_pkg::load_t       res_load;
  logic                 we;
  wlb_pkg::idx_t        waddr;
  wlb_pkg::load_t       wdata;
  logic                 live_set;
  logic                 live_clr;
  logic                 clr_all;

  always_comb begin
    if (pool_q == '0) begin
      pool_last = '0;
    end else if (32'(pool_q) > 32'(wlb_pkg::NUM_WORKERS)) begin
      pool_last = wlb_pkg::idx_t'(wlb_pkg::NUM_WORKERS - 1);
    end else begin
      pool_last = wlb_pkg::idx_t'(pool_q - wlb_pkg::pool_t'(1));
    end
  end

  assign worker_idx      = wlb_pkg::idx_t'(worker_q);
  assign worker_in_range = 32'(worker_q) < 32'(wlb_pkg::NUM_WORKERS);
  assign rel_ok          = worker_in_range &&
                           (mode_q ? live_q[worker_idx] : (worker_idx <= pool_last));
  assign lim_eff         = (limit_q == '0) ? wlb_pkg::DEFAULT_LIMIT : limit_q;
  assign cur_val         = rd_cvld_q ? rd_data_q : '0;
  assign cur_live        = live_q[rd_idx_q];

  assign rd_addr = (kind_q == wlb_pkg::KIND_RELEASE) ? worker_idx : cmd_i.scan_idx;

  assign sts_o.needs_scan = (kind_q == wlb_pkg::KIND_ACQUIRE) ||
                            (kind_q == wlb_pkg::KIND_RELEASE);
  assign sts_o.scan_last  = (kind_q == wlb_pkg::KIND_RELEASE) ? '0 :
                            (mode_q ? wlb_pkg::idx_t'(wlb_pkg::NUM_WORKERS - 1) : pool_last);
  assign sts_o.out_busy   = out_vld_q && !rsp_ready_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      pool_q  <= wlb_pkg::DEFAULT_POOL;
      limit_q <= wlb_pkg::DEFAULT_LIMIT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wlb_pkg::REG_MODE:  mode_q  <= cfg_data_i[0];
        wlb_pkg::REG_POOL:  pool_q  <= cfg_data_i[wlb_pkg::POOL_W-1:0];
        wlb_pkg::REG_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      kind_q   <= wlb_pkg::wlb_kind_e'(req_kind_i);
      worker_q <= req_worker_i;
    end
  end

  // count memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_cvld_q <= cnt_vld_q[rd_addr];
      rd_idx_q  <= rd_addr;
      rd_first_q <= (cmd_i.scan_idx == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd_en;
    end
  end

  // scan evaluation, one entry per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      idle_fnd_q <= 1'b0;
    end else if (cmd_i.load_req) begin
      hit_q      <= 1'b0;
      idle_fnd_q <= 1'b0;
    end else if (rd_pend_q) begin
      if (!hit_q && cur_live && (cur_val < lim_eff) && (cur_val < wlb_pkg::MAX_LOAD)) begin
        hit_q <= 1'b1;
      end
      if (!idle_fnd_q && !cur_live) begin
        idle_fnd_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      if (rd_first_q || (cur_val < best_val_q)) begin
        best_val_q <= cur_val;
        best_idx_q <= rd_idx_q;
      end
      if (!hit_q) begin
        hit_idx_q <= rd_idx_q;
        hit_val_q <= cur_val;
      end
      if (!idle_fnd_q) begin
        idle_idx_q <= rd_idx_q;
      end
    end
  end

  // result and update for the committed request
  always_comb begin
    res_assigned = '0;
    res_status   = wlb_pkg::ST_OK;
    res_retired  = 1'b0;
    res_load     = '0;
    we           = 1'b0;
    waddr        = best_idx_q;
    wdata        = '0;
    live_set     = 1'b0;
    live_clr     = 1'b0;
    clr_all      = 1'b0;
    unique case (kind_q)
      wlb_pkg::KIND_ACQUIRE: begin
        if (!mode_q) begin
          res_assigned = wlb_pkg::worker_t'(best_idx_q);
          if (best_val_q == wlb_pkg::MAX_LOAD) begin
            res_status = wlb_pkg::ST_IGNORED;
            res_load   = wlb_pkg::MAX_LOAD;
          end else begin
            we       = 1'b1;
            wdata    = best_val_q + wlb_pkg::load_t'(1);
            res_load = wdata;
          end
        end else if (hit_q) begin
          res_assigned = wlb_pkg::worker_t'(hit_idx_q);
          we           = 1'b1;
          waddr        = hit_idx_q;
          wdata        = hit_val_q + wlb_pkg::load_t'(1);
          res_load     = wdata;
        end else if (idle_fnd_q) begin
          // bring up the lowest idle slot with a fresh count
          res_assigned = wlb_pkg::worker_t'(idle_idx_q);
          we           = 1'b1;
          waddr        = idle_idx_q;
          wdata        = wlb_pkg::load_t'(1);
          res_load     = wdata;
          live_set     = 1'b1;
        end else begin
          res_status = wlb_pkg::ST_FULL;
        end
      end
      wlb_pkg::KIND_RELEASE: begin
        res_assigned = worker_q;
        waddr        = worker_idx;
        if (!rel_ok || (best_val_q == '0)) begin
          res_status = wlb_pkg::ST_IGNORED;
        end else begin
          we    = 1'b1;
          wdata = best_val_q - wlb_pkg::load_t'(1);
          if (mode_q && (wdata == '0) && (live_total_q > wlb_pkg::cnt_t'(1))) begin
            live_clr    = 1'b1;
            res_retired = 1'b1;
          end else begin
            res_load = wdata;
          end
        end
      end
      wlb_pkg::KIND_CLEAR: begin
        clr_all = 1'b1;
      end
      default: begin
        res_status = wlb_pkg::ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q    <= '0;
      live_q       <= {{(wlb_pkg::NUM_WORKERS-1){1'b0}}, 1'b1};
      live_total_q <= wlb_pkg::cnt_t'(1);
    end else if (cmd_i.commit) begin
      if (clr_all) begin
        cnt_vld_q <= '0;
      end else if (we) begin
        cnt_vld_q[waddr] <= 1'b1;
      end
      if (live_set) begin
        live_q[idle_idx_q] <= 1'b1;
        live_total_q       <= live_total_q + wlb_pkg::cnt_t'(1);
      end else if (live_clr) begin
        live_q[worker_idx] <= 1'b0;
        live_total_q       <= live_total_q - wlb_pkg::cnt_t'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_vld_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_assigned_q <= res_assigned;
      out_status_q   <= res_status;
      out_retired_q  <= res_retired;
      out_load_q     <= res_load;
    end
  end

  assign rsp_valid_o    = out_vld_q;
  assign rsp_assigned_o = out_assigned_q;
  assign rsp_status_o   = out_status_q;
  assign rsp_retired_o  = out_retired_q;
  assign rsp_load_o     = out_load_q;

endmodule

@@ src/worker_load_balancer.sv @@
// ----------------------------------------------------------------------------
// worker_load_balancer
// Least-loaded / first-fit worker assignment over a table of connection counts.
// ----------------------------------------------------------------------------
// One request is handled at a time. After acceptance the sequencer reads the
// count table one slot per cycle through its single registered read port: an
// acquire scans P slots in least-loaded mode, P being pool_size held to the
// range 1 to NUM_WORKERS, and all NUM_WORKERS slots in first-fit mode; a
// release reads one slot, and clear and unknown requests read none. A finished
// result sits in an output register, so the next request is accepted while it
// waits; that request only stalls at its commit step if the previous result
// has still not been taken.
// Register writes are taken every cycle and must be issued while idle.
module worker_load_balancer (
  input  logic      clk_i,
  input  logic      rst_ni,
  wlb_req_if.sink   req_i,
  wlb_rsp_if.source rsp_o,
  wlb_cfg_if.sink   cfg_i
);

  wlb_pkg::wlb_cmd_t cmd;
  wlb_pkg::wlb_sts_t sts;

  assign cfg_i.ready = 1'b1;

  wlb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wlb_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_kind_i     (req_i.kind),
    .req_worker_i   (req_i.worker),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_assigned_o (rsp_o.assigned),
    .rsp_status_o   (rsp_o.status),
    .rsp_retired_o  (rsp_o.retired),
    .rsp_load_o     (rsp_o.load),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

  // a new transaction is never taken on the cycle right after one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted twice in a row");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !sts.out_busy)
    else $error("commit while result register occupied");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> rsp_o.valid)
    else $error("committed result not presented");

  a_read_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> sts.needs_scan)
    else $error("table read for a request that needs no scan");

endmodule
